FILE: design/mm4_pkg.sv
// Shared types and fixed word widths for the 4x4 matrix multiplier.
`timescale 1ns / 1ps
package mm4_pkg;

  localparam int WORD_W = 32;
  localparam int PROD_W = 2 * WORD_W;
  localparam int OUT_IDX_W = 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [OUT_IDX_W-1:0] out_idx_t;

endpackage

FILE: design/mm4_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/matrix4x4_multiply.sv
// Top level of the matrix multiplier: load sequencer, shared MAC pipeline and saturation.
`timescale 1ns / 1ps
// Usage. The block computes C = A x B for square matrices of MATRIX_DIM rows in
// signed fixed point with FRACTION_BITS fraction bits (Q16.16 by default).
// Input transactions: drive left_element and right_element and raise start; a
// transaction is taken at each rising edge where start is high and busy is low.
// Elements arrive in row-major order, one element of A with the element of B at
// the same position. The transaction that fills the last position starts the
// computation and raises busy.
// Results: each element of C appears for exactly one cycle with valid high, in
// row-major order, with its row and column (masked to two bits), a clipped flag
// when the value saturated, and last_of_matrix on the final element. The
// receiver cannot stall, so results must be taken as they come.
// Timing: one shared 32x32 multiplier and one accumulator do all MATRIX_DIM**3
// multiply-accumulates, one per cycle. Each result shows up once the last
// product of its sum has been accumulated, saturated and registered. busy drops
// in the cycle that carries the final result, so a new matrix can start
// loading at once.
// Reset: rst is synchronous and active high; it returns the block to loading at
// the first position and drops valid. The element stores are not cleared.
module matrix4x4_multiply #(
  parameter int MATRIX_DIM    = 4,
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mm4_pkg::word_t    left_element,
  input  mm4_pkg::word_t    right_element,
  output logic              valid,
  output mm4_pkg::word_t    product_element,
  output mm4_pkg::out_idx_t row_index,
  output mm4_pkg::out_idx_t column_index,
  output logic              clipped,
  output logic              last_of_matrix
);

  import mm4_pkg::*;

  localparam int CELLS  = MATRIX_DIM * MATRIX_DIM;
  localparam int IDX_W  = $clog2(MATRIX_DIM);
  localparam int ADDR_W = $clog2(CELLS);
  // Headroom for the sum of MATRIX_DIM full-width products.
  localparam int ACC_W  = PROD_W + IDX_W + 1;

  localparam logic [IDX_W-1:0]  IDX_MAX  = IDX_W'(MATRIX_DIM - 1);
  localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(CELLS - 1);

  // Sequencer states.
  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]        state;
  logic [ADDR_W-1:0] load_pos;
  logic              accept;

  // Issue counters: row, column and inner index of the product being read.
  logic [IDX_W-1:0]  r_cnt;
  logic [IDX_W-1:0]  c_cnt;
  logic [IDX_W-1:0]  k_cnt;
  logic              issue;
  logic              issue_last;
  logic [ADDR_W-1:0] left_rd_addr;
  logic [ADDR_W-1:0] right_rd_addr;

  // Stage 1: store read data. Stage 2: product. Stage 3: accumulator.
  word_t             left_data;
  word_t             right_data;
  logic              s1_v;
  logic              s1_first;
  logic              s1_end;
  logic [IDX_W-1:0]  s1_r;
  logic [IDX_W-1:0]  s1_c;
  prod_t             prod;
  logic              s2_v;
  logic              s2_first;
  logic              s2_end;
  logic [IDX_W-1:0]  s2_r;
  logic [IDX_W-1:0]  s2_c;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] prod_ext;
  logic              s3_done;
  logic [IDX_W-1:0]  s3_r;
  logic [IDX_W-1:0]  s3_c;
  logic              s3_final;

  // Saturation of the finished sum.
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-WORD_W:0]    upper;
  logic                     fits;
  word_t                    sat_value;
  logic [IDX_W+1:0]         row_ext;
  logic [IDX_W+1:0]         col_ext;

  assign busy   = (state != ST_LOAD);
  assign accept = start && !busy;

  // Element stores; written while loading, read while computing.
  mm4_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_left_ram (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (load_pos),
    .wr_data (left_element),
    .rd_addr (left_rd_addr),
    .rd_data (left_data)
  );

  mm4_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_right_ram (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (load_pos),
    .wr_data (right_element),
    .rd_addr (right_rd_addr),
    .rd_data (right_data)
  );

  // A is read along row r, B down column c.
  assign left_rd_addr  = ADDR_W'(r_cnt) * ADDR_W'(MATRIX_DIM) + ADDR_W'(k_cnt);
  assign right_rd_addr = ADDR_W'(k_cnt) * ADDR_W'(MATRIX_DIM) + ADDR_W'(c_cnt);

  assign issue      = (state == ST_RUN);
  assign issue_last = (r_cnt == IDX_MAX) && (c_cnt == IDX_MAX) && (k_cnt == IDX_MAX);
  assign s3_final   = (s3_r == IDX_MAX) && (s3_c == IDX_MAX);

  // Sequencer: load positions, then step the issue counters once per cycle, then wait for the final sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      load_pos <= '0;
      r_cnt    <= '0;
      c_cnt    <= '0;
      k_cnt    <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (load_pos == ADDR_MAX) begin
              load_pos <= '0;
              r_cnt    <= '0;
              c_cnt    <= '0;
              k_cnt    <= '0;
              state    <= ST_RUN;
            end else begin
              load_pos <= load_pos + 1'b1;
            end
          end
        end
        ST_RUN: begin
          if (issue_last) begin
            state <= ST_DRAIN;
          end
          if (k_cnt == IDX_MAX) begin
            k_cnt <= '0;
            if (c_cnt == IDX_MAX) begin
              c_cnt <= '0;
              r_cnt <= r_cnt + 1'b1;
            end else begin
              c_cnt <= c_cnt + 1'b1;
            end
          end else begin
            k_cnt <= k_cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          // The final sum is in the accumulator; its result goes out this edge.
          if (s3_done && s3_final) begin
            state <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Pipeline control tags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
      s3_done <= 1'b0;
    end else begin
      s1_v    <= issue;
      s2_v    <= s1_v;
      s3_done <= s2_v && s2_end;
    end
  end

  // Shared multiplier and accumulator.
  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    s1_first <= (k_cnt == '0);
    s1_end   <= (k_cnt == IDX_MAX);
    s1_r     <= r_cnt;
    s1_c     <= c_cnt;
    prod     <= prod_t'(left_data) * prod_t'(right_data);
    s2_first <= s1_first;
    s2_end   <= s1_end;
    s2_r     <= s1_r;
    s2_c     <= s1_c;
    if (s2_v) begin
      acc  <= s2_first ? prod_ext : acc + prod_ext;
      s3_r <= s2_r;
      s3_c <= s2_c;
    end
  end

  // Arithmetic shift truncates toward minus infinity; the result fits in a
  // word when every bit above bit 30 matches the sign.
  assign shifted   = acc >>> FRACTION_BITS;
  assign upper     = shifted[ACC_W-1:WORD_W-1];
  assign fits      = (&upper) || !(|upper);
  assign sat_value = fits ? shifted[WORD_W-1:0] :
                     (shifted[ACC_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} :
                                         {1'b0, {(WORD_W-1){1'b1}}});
  assign row_ext   = {2'b00, s3_r};
  assign col_ext   = {2'b00, s3_c};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= s3_done;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_done) begin
      product_element <= sat_value;
      row_index       <= row_ext[OUT_IDX_W-1:0];
      column_index    <= col_ext[OUT_IDX_W-1:0];
      clipped         <= !fits;
      last_of_matrix  <= s3_final;
    end
  end

  // Results only come out of a computation.
  a_valid_from_run: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy))
    else $error("result strobe without a computation in progress");

  // The block is ready again by the time the final result is shown.
  a_idle_at_last: assert property (@(posedge clk) disable iff (rst)
    (valid && last_of_matrix) |-> !busy)
    else $error("still busy while the final result is shown");

  // A computation starts only once every position has been loaded.
  a_start_after_full_load: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> ($past(load_pos) == ADDR_MAX) && (load_pos == '0))
    else $error("computation started before the matrices were complete");

endmodule
